// ----- src/fre_pkg.sv -----
// shared types and constants for the fisheye remap pipeline
package fre_pkg;

	localparam int CORDIC_STEPS = 16;
	localparam int HALF_PI_Q16 = 102944;
	localparam int PI_Q14 = 51472;

	localparam logic [2:0] REG_ROW0 = 3'd0;
	localparam logic [2:0] REG_ROW1 = 3'd1;
	localparam logic [2:0] REG_ROW2 = 3'd2;
	localparam logic [2:0] REG_INV_SCALE = 3'd3;
	localparam logic [2:0] REG_FOCAL_K = 3'd4;
	localparam logic [2:0] REG_HALF_ROWS = 3'd5;
	localparam logic [2:0] REG_CENTER_X = 3'd6;
	localparam logic [2:0] REG_MAX_ANGLE = 3'd7;

	function automatic logic [16:0] atan_lut(input int i);
		case (i)
			0: atan_lut = 17'd51472;
			1: atan_lut = 17'd30386;
			2: atan_lut = 17'd16055;
			3: atan_lut = 17'd8150;
			4: atan_lut = 17'd4091;
			5: atan_lut = 17'd2047;
			6: atan_lut = 17'd1024;
			7: atan_lut = 17'd512;
			8: atan_lut = 17'd256;
			9: atan_lut = 17'd128;
			10: atan_lut = 17'd64;
			11: atan_lut = 17'd32;
			12: atan_lut = 17'd16;
			13: atan_lut = 17'd8;
			14: atan_lut = 17'd4;
			15: atan_lut = 17'd2;
			default: atan_lut = 17'd0;
		endcase
	endfunction

endpackage

// ----- src/fisheye_rotated_remap_top.sv -----
// fisheye remap address generator: pipelined rotate, radius, angle and divide
// one item per clock when not stalled; items pass through four stages of scaling,
// rotation and squares, a square root (COORD_BITS+21 stages) of one result bit per
// stage, a cordic pre-rotation and one stage per cordic step, three stages for the
// angle and the products, a restoring divider (COORD_BITS+37 stages) of one quotient
// bit per stage and an output register. a stall at the output freezes the whole
// pipeline. in_view travels on m_tuser; an item out of view carries zero coordinates.
// registers must be written by the user only while no item is in flight (unenforced).
module fisheye_rotated_remap_top
	import fre_pkg::*;
#(
	parameter int COORD_BITS = 12,
	parameter int FRAC_BITS = 16
) (
	input  logic clk,
	input  logic arst_n,
	input  logic s_tvalid,
	output logic s_tready,
	input  logic [8*((2*COORD_BITS+7)/8)-1:0] s_tdata, // offset_x, offset_y
	output logic m_tvalid,
	input  logic m_tready,
	output logic [8*((2*COORD_BITS+7)/8)-1:0] m_tdata, // src_x, src_y
	output logic m_tuser, // in_view
	input  logic psel,
	input  logic penable,
	input  logic pwrite,
	input  logic [5:0] paddr,
	input  logic [63:0] pwdata,
	output logic [63:0] prdata,
	output logic pready
);

	localparam int EB = FRAC_BITS + 2;
	localparam int RW = (3 * EB > 64) ? 64 : 3 * EB;
	localparam int VW = COORD_BITS + 17;          // scaled offset, signed
	localparam int PW = VW + EB + 2 - FRAC_BITS;  // rotated component, signed
	localparam int SW = 2 * PW;                   // squared sum, unsigned
	localparam int RDW = PW;                      // radius width
	localparam int SQS = RDW;                     // sqrt stages
	localparam int CW = PW + 3;                   // cordic xy width
	localparam int AKW = 32;                      // angle*focal
	localparam int DENW = RDW + 18;
	localparam int NUMW = PW + AKW + 1;           // |p|*ak
	localparam int QW = NUMW - 18 + 1;            // quotient bits
	localparam int DIVS = QW;
	localparam int NS = 4 + SQS + 1 + CORDIC_STEPS + 3 + DIVS + 1;

	logic [RW-1:0] row_q [3];
	logic [15:0] inv_scale_q, focal_k_q, max_angle_q;
	logic [COORD_BITS-1:0] half_rows_q, center_x_q;

	assign pready = 1'b1;
	logic [2:0] ridx;
	assign ridx = paddr[5:3];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			row_q[0] <= RW'(64'd1 << FRAC_BITS);
			row_q[1] <= RW'(64'd1 << (FRAC_BITS + EB));
			row_q[2] <= RW'(64'd1 << (FRAC_BITS + 2 * EB));
			inv_scale_q <= 16'd8192;
			focal_k_q <= 16'd4800;
			half_rows_q <= COORD_BITS'(240);
			center_x_q <= COORD_BITS'(320);
			max_angle_q <= 16'd31457;
		end else if (psel && penable && pwrite) begin
			case (ridx)
				REG_ROW0: row_q[0] <= pwdata[RW-1:0];
				REG_ROW1: row_q[1] <= pwdata[RW-1:0];
				REG_ROW2: row_q[2] <= pwdata[RW-1:0];
				REG_INV_SCALE: inv_scale_q <= pwdata[15:0];
				REG_FOCAL_K: focal_k_q <= pwdata[15:0];
				REG_HALF_ROWS: half_rows_q <= pwdata[COORD_BITS-1:0];
				REG_CENTER_X: center_x_q <= pwdata[COORD_BITS-1:0];
				REG_MAX_ANGLE: max_angle_q <= pwdata[15:0];
				default: ;
			endcase
		end
	end

	always_comb begin
		case (ridx)
			REG_ROW0: prdata = 64'(row_q[0]);
			REG_ROW1: prdata = 64'(row_q[1]);
			REG_ROW2: prdata = 64'(row_q[2]);
			REG_INV_SCALE: prdata = 64'(inv_scale_q);
			REG_FOCAL_K: prdata = 64'(focal_k_q);
			REG_HALF_ROWS: prdata = 64'(half_rows_q);
			REG_CENTER_X: prdata = 64'(center_x_q);
			REG_MAX_ANGLE: prdata = 64'(max_angle_q);
			default: prdata = '0;
		endcase
	end

	// global stall: whole pipe advances when output free
	logic adv;
	logic [NS-1:0] vld_q;
	assign adv = !m_tvalid || m_tready;
	assign s_tready = adv;
	assign m_tvalid = vld_q[NS-1];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_q <= '0;
		end else if (adv) begin
			vld_q <= {vld_q[NS-2:0], s_tvalid};
		end
	end

	function automatic logic signed [EB-1:0] elem(input logic [RW-1:0] r, input int c);
		logic [3*EB-1:0] w;
		w = (3*EB)'(r);
		elem = w[c*EB +: EB];
	endfunction

	// stage 1: scale offsets
	logic signed [VW-1:0] v0_s1, v1_s1, v2_s1;
	always_ff @(posedge clk) begin
		if (adv) begin
			v0_s1 <= VW'($signed(s_tdata[COORD_BITS-1:0]) * $signed({1'b0, inv_scale_q}));
			v1_s1 <= VW'($signed(s_tdata[2*COORD_BITS-1:COORD_BITS])
				* $signed({1'b0, inv_scale_q}));
			v2_s1 <= VW'({1'b0, half_rows_q, 12'd0});
		end
	end

	// stage 2: nine products
	localparam int MW = VW + EB;
	logic signed [MW-1:0] m_s2 [3][3];
	always_ff @(posedge clk) begin
		if (adv) begin
			for (int r = 0; r < 3; r++) begin
				m_s2[r][0] <= MW'(elem(row_q[r], 0) * v0_s1);
				m_s2[r][1] <= MW'(elem(row_q[r], 1) * v1_s1);
				m_s2[r][2] <= MW'(elem(row_q[r], 2) * v2_s1);
			end
		end
	end

	// stage 3: row sums, truncating divide by 2^FRAC_BITS
	logic signed [PW-1:0] p_s3 [3];
	always_ff @(posedge clk) begin
		if (adv) begin
			for (int r = 0; r < 3; r++) begin
				logic signed [MW+1:0] acc;
				logic signed [MW+1:0] adj;
				acc = (MW+2)'(m_s2[r][0]) + (MW+2)'(m_s2[r][1]) + (MW+2)'(m_s2[r][2]);
				adj = acc[MW+1] ? acc + (MW+2)'((64'd1 << FRAC_BITS) - 1) : acc;
				p_s3[r] <= PW'(adj >>> FRAC_BITS);
			end
		end
	end

	// stage 4: squares sum
	logic [SW-1:0] sq_s4;
	logic signed [PW-1:0] px_s4, py_s4, pz_s4;
	always_ff @(posedge clk) begin
		if (adv) begin
			sq_s4 <= SW'(p_s3[0] * p_s3[0]) + SW'(p_s3[1] * p_s3[1]);
			px_s4 <= p_s3[0];
			py_s4 <= p_s3[1];
			pz_s4 <= p_s3[2];
		end
	end

	// isqrt: one result bit per stage
	logic [SW-1:0] sqn_q [SQS+1];
	logic [RDW-1:0] sqr_q [SQS+1];
	logic signed [PW-1:0] sqx_q [SQS+1], sqy_q [SQS+1], sqz_q [SQS+1];
	always_comb begin
		sqn_q[0] = sq_s4;
		sqr_q[0] = '0;
		sqx_q[0] = px_s4;
		sqy_q[0] = py_s4;
		sqz_q[0] = pz_s4;
	end
	for (genvar g = 0; g < SQS; g++) begin : g_sqrt
		localparam int B = SQS - 1 - g;
		always_ff @(posedge clk) begin
			if (adv) begin
				logic [SW+1:0] trial;
				trial = ((SW+2)'(sqr_q[g]) << (B + 1)) + ((SW+2)'(1) << (2 * B));
				if ((SW+2)'(sqn_q[g]) >= trial) begin
					sqn_q[g+1] <= SW'((SW+2)'(sqn_q[g]) - trial);
					sqr_q[g+1] <= sqr_q[g] | (RDW'(1) << B);
				end else begin
					sqn_q[g+1] <= sqn_q[g];
					sqr_q[g+1] <= sqr_q[g];
				end
				sqx_q[g+1] <= sqx_q[g];
				sqy_q[g+1] <= sqy_q[g];
				sqz_q[g+1] <= sqz_q[g];
			end
		end
	end

	// cordic pre-rotation stage
	typedef struct packed {
		logic signed [PW-1:0] px;
		logic signed [PW-1:0] py;
		logic [RDW-1:0] rad;
		logic zneg;
	} side_t;

	logic signed [CW-1:0] cx_q [CORDIC_STEPS+1], cy_q [CORDIC_STEPS+1];
	logic signed [19:0] ca_q [CORDIC_STEPS+1];
	side_t cs_q [CORDIC_STEPS+1];
	always_ff @(posedge clk) begin
		if (adv) begin
			cs_q[0] <= '{px: sqx_q[SQS], py: sqy_q[SQS], rad: sqr_q[SQS],
				zneg: sqz_q[SQS][PW-1]};
			if (sqz_q[SQS][PW-1]) begin
				cx_q[0] <= CW'($signed({1'b0, sqr_q[SQS]}));
				cy_q[0] <= -CW'(sqz_q[SQS]);
				ca_q[0] <= 20'(HALF_PI_Q16);
			end else begin
				cx_q[0] <= CW'(sqz_q[SQS]);
				cy_q[0] <= CW'($signed({1'b0, sqr_q[SQS]}));
				ca_q[0] <= '0;
			end
		end
	end
	for (genvar g = 0; g < CORDIC_STEPS; g++) begin : g_cordic
		always_ff @(posedge clk) begin
			if (adv) begin
				if (!cy_q[g][CW-1]) begin
					cx_q[g+1] <= cx_q[g] + (cy_q[g] >>> g);
					cy_q[g+1] <= cy_q[g] - (cx_q[g] >>> g);
					ca_q[g+1] <= ca_q[g] + 20'(atan_lut(g));
				end else begin
					cx_q[g+1] <= cx_q[g] - (cy_q[g] >>> g);
					cy_q[g+1] <= cy_q[g] + (cx_q[g] >>> g);
					ca_q[g+1] <= ca_q[g] - 20'(atan_lut(g));
				end
				cs_q[g+1] <= cs_q[g];
			end
		end
	end

	// angle finish, view test
	logic [16:0] ang_s5;
	side_t sd_s5;
	logic view_s5;
	always_ff @(posedge clk) begin
		if (adv) begin
			logic [16:0] a;
			if (cs_q[CORDIC_STEPS].rad == '0)
				a = cs_q[CORDIC_STEPS].zneg ? 17'(PI_Q14) : 17'd0;
			else if (ca_q[CORDIC_STEPS][19])
				a = '0;
			else
				a = 17'(ca_q[CORDIC_STEPS] >>> 2);
			ang_s5 <= a;
			view_s5 <= a < {1'b0, max_angle_q};
			sd_s5 <= cs_q[CORDIC_STEPS];
		end
	end

	// ak and numerator magnitudes
	typedef struct packed {
		logic [NUMW-1:0] mag;
		logic neg;
	} num_t;
	num_t nx_s6, ny_s6;
	side_t sd_s6;
	logic view_s6;
	logic [AKW-1:0] ak_s6;
	always_ff @(posedge clk) begin
		if (adv) begin
			ak_s6 <= AKW'(ang_s5 * focal_k_q);
			sd_s6 <= sd_s5;
			view_s6 <= view_s5;
		end
	end
	always_ff @(posedge clk) begin
		if (adv) begin
			nx_s6.neg <= sd_s6.px[PW-1];
			ny_s6.neg <= sd_s6.py[PW-1];
			nx_s6.mag <= NUMW'((sd_s6.px[PW-1] ? -sd_s6.px : sd_s6.px)) * NUMW'(ak_s6);
			ny_s6.mag <= NUMW'((sd_s6.py[PW-1] ? -sd_s6.py : sd_s6.py)) * NUMW'(ak_s6);
		end
	end
	side_t sd_s7;
	logic view_s7;
	always_ff @(posedge clk) begin
		if (adv) begin
			sd_s7 <= sd_s6;
			view_s7 <= view_s6;
		end
	end

	// restoring divider, one quotient bit per stage, both axes
	logic [NUMW-1:0] rx_q [DIVS+1], ry_q [DIVS+1];
	logic [QW-1:0] qx_q [DIVS+1], qy_q [DIVS+1];
	logic negx_q [DIVS+1], negy_q [DIVS+1], view_q [DIVS+1], zr_q [DIVS+1];
	logic [RDW-1:0] dv_q [DIVS+1];
	always_comb begin
		rx_q[0] = nx_s6.mag;
		ry_q[0] = ny_s6.mag;
		qx_q[0] = '0;
		qy_q[0] = '0;
		negx_q[0] = nx_s6.neg;
		negy_q[0] = ny_s6.neg;
		view_q[0] = view_s7;
		zr_q[0] = sd_s7.rad == '0;
		dv_q[0] = sd_s7.rad;
	end
	for (genvar g = 0; g < DIVS; g++) begin : g_div
		localparam int B = DIVS - 1 - g;
		always_ff @(posedge clk) begin
			if (adv) begin
				logic [NUMW+DENW:0] d;
				d = (NUMW+DENW+1)'(dv_q[g]) << (B + 18);
				if ((NUMW+DENW+1)'(rx_q[g]) >= d && dv_q[g] != '0) begin
					rx_q[g+1] <= NUMW'((NUMW+DENW+1)'(rx_q[g]) - d);
					qx_q[g+1] <= qx_q[g] | (QW'(1) << B);
				end else begin
					rx_q[g+1] <= rx_q[g];
					qx_q[g+1] <= qx_q[g];
				end
				if ((NUMW+DENW+1)'(ry_q[g]) >= d && dv_q[g] != '0) begin
					ry_q[g+1] <= NUMW'((NUMW+DENW+1)'(ry_q[g]) - d);
					qy_q[g+1] <= qy_q[g] | (QW'(1) << B);
				end else begin
					ry_q[g+1] <= ry_q[g];
					qy_q[g+1] <= qy_q[g];
				end
				negx_q[g+1] <= negx_q[g];
				negy_q[g+1] <= negy_q[g];
				view_q[g+1] <= view_q[g];
				zr_q[g+1] <= zr_q[g];
				dv_q[g+1] <= dv_q[g];
			end
		end
	end

	// centre plus signed quotient, saturate
	localparam int TW = QW + 2;
	localparam logic [TW-1:0] TOP = TW'((64'd1 << COORD_BITS) - 1);
	function automatic logic [COORD_BITS-1:0] sat(input logic [COORD_BITS-1:0] c,
		input logic [QW-1:0] q, input logic neg, input logic rem);
		logic signed [TW-1:0] s;
		// a negative offset with a remainder floors the sum one step further
		s = $signed(TW'(c)) + (neg ? -$signed(TW'(q) + TW'(rem)) : $signed(TW'(q)));
		if (s < 0) sat = '0;
		else if (s > $signed(TOP)) sat = '1;
		else sat = s[COORD_BITS-1:0];
	endfunction

	logic [COORD_BITS-1:0] ox_q, oy_q;
	logic ov_q;
	always_ff @(posedge clk) begin
		if (adv) begin
			ov_q <= view_q[DIVS];
			if (!view_q[DIVS]) begin
				ox_q <= '0;
				oy_q <= '0;
			end else if (zr_q[DIVS]) begin
				ox_q <= center_x_q;
				oy_q <= half_rows_q;
			end else begin
				ox_q <= sat(center_x_q, qx_q[DIVS], negx_q[DIVS], rx_q[DIVS] != '0);
				oy_q <= sat(half_rows_q, qy_q[DIVS], negy_q[DIVS], ry_q[DIVS] != '0);
			end
		end
	end

	assign m_tdata = $bits(m_tdata)'({oy_q, ox_q});
	assign m_tuser = ov_q;

endmodule
